// ===== rtl/ysh_pkg.sv =====
// Shared types, constants and lookup tables for the YOLO split head decoder.
// Used by ysh_cfg, ysh_collect, ysh_core and yolo_split_head_decode_top.
package ysh_pkg;

	// Block configuration.
	localparam int NUM_CLASSES = 80;
	localparam int GRID_BITS   = 7;

	// Field widths.
	localparam int BYTE_W  = 8;
	localparam int CELL_W  = 7;
	localparam int LOGIT_W = 25;
	localparam int EDGE_W  = 18;
	localparam int CFG_IW  = 3;
	localparam int CFG_DW  = 25;

	// Configuration register indexes.
	localparam logic [CFG_IW-1:0] CFG_THRESHOLD = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_ZP_A      = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_ZP_B      = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_ZP_C      = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_STEP_A    = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_STEP_B    = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_STEP_C    = 3'd6;

	localparam logic [15:0] STEP_RESET = 16'd4096;

	// Highest valid scale and anchor index; larger codes fold onto it.
	localparam logic [1:0] INDEX_MAX = 2'd2;

	// Saturation limits of a box edge (signed Q13.4).
	localparam logic [EDGE_W-1:0] EDGE_MIN = 18'h20000;
	localparam logic [EDGE_W-1:0] EDGE_MAX = 18'h1FFFF;

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		logic signed [LOGIT_W-1:0] thr;
		logic [2:0][7:0]           zp;
		logic [2:0][15:0]          st;
	} cfg_t;

	// One finished cell, captured on its last byte.
	typedef struct packed {
		logic [3:0][BYTE_W-1:0] box;
		logic [BYTE_W-1:0]      obj;
		logic [BYTE_W-1:0]      cls_v;
		logic [BYTE_W-1:0]      cls_i;
		logic [1:0]             sc;
		logic [1:0]             an;
		logic [CELL_W-1:0]      cx;
		logic [CELL_W-1:0]      cy;
	} cell_t;

	// Sigmoid in Q0.16 at |v| = k/2, k = 0..16.
	function automatic logic [15:0] sig_tab(input logic [4:0] k);
		logic [15:0] s;
		case (k)
			5'd0: s = 16'd32768;
			5'd1: s = 16'd40793;
			5'd2: s = 16'd47911;
			5'd3: s = 16'd53581;
			5'd4: s = 16'd57724;
			5'd5: s = 16'd60565;
			5'd6: s = 16'd62428;
			5'd7: s = 16'd63615;
			5'd8: s = 16'd64357;
			5'd9: s = 16'd64816;
			5'd10: s = 16'd65097;
			5'd11: s = 16'd65269;
			5'd12: s = 16'd65374;
			5'd13: s = 16'd65438;
			5'd14: s = 16'd65476;
			5'd15: s = 16'd65500;
			default: s = 16'd65514;
		endcase
		return s;
	endfunction

	// Anchor width gain per scale and anchor.
	function automatic logic [8:0] gain_w(input logic [1:0] sc, input logic [1:0] an);
		logic [8:0] g;
		case ({sc, an})
			4'b0000: g = 9'd10;
			4'b0001: g = 9'd16;
			4'b0010: g = 9'd33;
			4'b0100: g = 9'd30;
			4'b0101: g = 9'd62;
			4'b0110: g = 9'd59;
			4'b1000: g = 9'd116;
			4'b1001: g = 9'd156;
			4'b1010: g = 9'd373;
			default: g = 9'd0;
		endcase
		return g;
	endfunction

	// Anchor height gain per scale and anchor.
	function automatic logic [8:0] gain_h(input logic [1:0] sc, input logic [1:0] an);
		logic [8:0] g;
		case ({sc, an})
			4'b0000: g = 9'd13;
			4'b0001: g = 9'd30;
			4'b0010: g = 9'd23;
			4'b0100: g = 9'd61;
			4'b0101: g = 9'd45;
			4'b0110: g = 9'd119;
			4'b1000: g = 9'd90;
			4'b1001: g = 9'd198;
			4'b1010: g = 9'd326;
			default: g = 9'd0;
		endcase
		return g;
	endfunction

endpackage

// ===== rtl/ysh_cfg.sv =====
// Configuration register file: threshold, zero points and steps per scale.
// Depends on ysh_pkg.
module ysh_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [ysh_pkg::CFG_IW-1:0] wr_index,
	input  logic [ysh_pkg::CFG_DW-1:0] wr_data,
	output ysh_pkg::cfg_t              cfg
);
	import ysh_pkg::*;

	cfg_t cfg_q;

	// Register writes; indexes outside the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr <= '0;
			cfg_q.zp  <= '0;
			cfg_q.st  <= {STEP_RESET, STEP_RESET, STEP_RESET};
		end else if (wr_en) begin
			case (wr_index)
				CFG_THRESHOLD: cfg_q.thr <= $signed(wr_data[LOGIT_W-1:0]);
				CFG_ZP_A: cfg_q.zp[0] <= wr_data[7:0];
				CFG_ZP_B: cfg_q.zp[1] <= wr_data[7:0];
				CFG_ZP_C: cfg_q.zp[2] <= wr_data[7:0];
				CFG_STEP_A: cfg_q.st[0] <= wr_data[15:0];
				CFG_STEP_B: cfg_q.st[1] <= wr_data[15:0];
				CFG_STEP_C: cfg_q.st[2] <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/ysh_collect.sv =====
// Byte collector: stores box and objectness bytes, tracks the best class and
// captures a finished cell for the arithmetic core. Depends on ysh_pkg.
module ysh_collect (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [1:0]                 scale_index,
	input  logic [1:0]                 anchor_index,
	input  logic [ysh_pkg::CELL_W-1:0] cell_x,
	input  logic [ysh_pkg::CELL_W-1:0] cell_y,
	input  logic [ysh_pkg::BYTE_W-1:0] layer_value,
	input  logic                       last_of_cell,
	output logic                       start,
	output ysh_pkg::cell_t             snap
);
	import ysh_pkg::*;

	localparam logic [CELL_W-1:0] GRID_MASK = CELL_W'((1 << GRID_BITS) - 1);

	logic [7:0]        pos_q;
	logic [BYTE_W-1:0] box_q [4];
	logic [BYTE_W-1:0] obj_q;
	logic [BYTE_W-1:0] best_v_q;
	logic [BYTE_W-1:0] best_i_q;
	logic              start_q;
	cell_t             snap_q;

	logic [7:0]        ci;
	logic              cand;
	logic [BYTE_W-1:0] nb_v;
	logic [BYTE_W-1:0] nb_i;

	// Best class candidate for this byte; the first maximum wins.
	always_comb begin
		ci   = pos_q - 8'd5;
		cand = (pos_q >= 8'd5) && ({1'b0, ci} < 9'(NUM_CLASSES)) &&
			((ci == 8'd0) || (layer_value > best_v_q));
		nb_v = cand ? layer_value : best_v_q;
		nb_i = cand ? ci : best_i_q;
	end

	// Position counter, best class and the start pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			best_v_q <= '0;
			best_i_q <= '0;
			start_q  <= 1'b0;
		end else begin
			start_q <= accept && last_of_cell && (pos_q >= 8'd5);
			if (accept) begin
				if (!last_of_cell) begin
					if (pos_q != 8'd255) begin
						pos_q <= pos_q + 8'd1;
					end
					best_v_q <= nb_v;
					best_i_q <= nb_i;
				end else begin
					pos_q    <= '0;
					best_v_q <= '0;
					best_i_q <= '0;
				end
			end
		end
	end

	// Box and objectness bytes, and the captured cell.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_q < 8'd4) begin
				box_q[pos_q[1:0]] <= layer_value;
			end
			if (pos_q == 8'd4) begin
				obj_q <= layer_value;
			end
			if (last_of_cell && (pos_q >= 8'd5)) begin
				snap_q.box   <= {box_q[3], box_q[2], box_q[1], box_q[0]};
				snap_q.obj   <= obj_q;
				snap_q.cls_v <= nb_v;
				snap_q.cls_i <= nb_i;
				snap_q.sc    <= (scale_index > INDEX_MAX) ? INDEX_MAX : scale_index;
				snap_q.an    <= (anchor_index > INDEX_MAX) ? INDEX_MAX : anchor_index;
				snap_q.cx    <= cell_x & GRID_MASK;
				snap_q.cy    <= cell_y & GRID_MASK;
			end
		end
	end

	assign start = start_q;
	assign snap  = snap_q;

endmodule

// ===== rtl/ysh_core.sv =====
// Cell arithmetic: dequantization, threshold, sigmoid, confidence and box
// edges on one shared multiplier under a small sequencer. Depends on ysh_pkg.
module ysh_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  ysh_pkg::cell_t             snap,
	input  ysh_pkg::cfg_t              cfg,
	output logic                       busy,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic [ysh_pkg::BYTE_W-1:0] class_index,
	output logic [15:0]                confidence,
	output logic [ysh_pkg::EDGE_W-1:0] box_top,
	output logic [ysh_pkg::EDGE_W-1:0] box_left,
	output logic [ysh_pkg::EDGE_W-1:0] box_bottom,
	output logic [ysh_pkg::EDGE_W-1:0] box_right
);
	import ysh_pkg::*;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DQ   = 4'd1;
	localparam logic [3:0] ST_THR  = 4'd2;
	localparam logic [3:0] ST_SGM  = 4'd3;
	localparam logic [3:0] ST_SGF  = 4'd4;
	localparam logic [3:0] ST_CONF = 4'd5;
	localparam logic [3:0] ST_SQW  = 4'd6;
	localparam logic [3:0] ST_GW   = 4'd7;
	localparam logic [3:0] ST_SQH  = 4'd8;
	localparam logic [3:0] ST_GH   = 4'd9;
	localparam logic [3:0] ST_CEN  = 4'd10;
	localparam logic [3:0] ST_EDGE = 4'd11;
	localparam logic [3:0] ST_PUT  = 4'd12;

	// Slots of the logit and sigmoid registers.
	localparam logic [2:0] VI_OBJ  = 3'd0;
	localparam logic [2:0] VI_CLS  = 3'd1;
	localparam logic [2:0] VI_BOX0 = 3'd2;
	localparam logic [2:0] VI_BOX1 = 3'd3;
	localparam logic [2:0] VI_BOX2 = 3'd4;
	localparam logic [2:0] VI_BOX3 = 3'd5;

	localparam logic [47:0] ROUND_HALF = 48'h000_0800_0000;

	logic [3:0] state_q;
	logic [2:0] k_q;
	logic [1:0] e_q;
	logic       out_valid_q;

	logic signed [LOGIT_W-1:0] lg_q [6];
	logic [15:0]               sg_q [6];
	logic [23:0]               pr_q;
	logic [3:0]                ti_q;
	logic                      neg_q;
	logic                      sat_q;
	logic [15:0]               conf_q;
	logic [31:0]               sq_q;
	logic [41:0]               hw_q;
	logic [41:0]               hh_q;
	logic [47:0]               cen_x_q;
	logic [47:0]               cen_y_q;
	logic [EDGE_W-1:0]         edge_q [4];

	logic [BYTE_W-1:0]         out_cls_q;
	logic [15:0]               out_conf_q;
	logic [EDGE_W-1:0]         out_edge_q [4];

	logic [7:0]                zp_sel;
	logic [15:0]               st_sel;
	logic [BYTE_W-1:0]         raw_k;
	logic signed [8:0]         dq_diff;
	logic signed [LOGIT_W-1:0] lg_k;
	logic [LOGIT_W-1:0]        mag;
	logic [12:0]               diff;
	logic [12:0]               step;
	logic [15:0]               smag;
	logic [15:0]               sg_new;
	logic signed [32:0]        mul_a;
	logic signed [16:0]        mul_b;
	logic signed [49:0]        mul_p;
	logic [25:0]               px;
	logic [25:0]               py;
	logic [4:0]                shamt;
	logic [47:0]               h_e;
	logic [47:0]               t_e;
	logic [EDGE_W-1:0]         edge_new;
	logic                      pass;
	logic                      out_free;

	// Per-scale dequantization parameters and the byte for the current slot.
	always_comb begin
		zp_sel = cfg.zp[snap.sc];
		st_sel = cfg.st[snap.sc];
		case (k_q)
			VI_OBJ: raw_k = snap.obj;
			VI_CLS: raw_k = snap.cls_v;
			VI_BOX0: raw_k = snap.box[0];
			VI_BOX1: raw_k = snap.box[1];
			VI_BOX2: raw_k = snap.box[2];
			VI_BOX3: raw_k = snap.box[3];
			default: raw_k = snap.obj;
		endcase
		dq_diff = $signed({1'b0, raw_k}) - $signed({1'b0, zp_sel});
	end

	// Sigmoid lookup: magnitude, segment, slope, and the finished value.
	always_comb begin
		lg_k   = lg_q[k_q];
		mag    = lg_k[LOGIT_W-1] ? LOGIT_W'(-lg_k) : LOGIT_W'(lg_k);
		diff   = 13'(sig_tab({1'b0, mag[14:11]} + 5'd1) - sig_tab({1'b0, mag[14:11]}));
		step   = 13'((25'(pr_q) + 25'd1024) >> 11);
		smag   = sat_q ? sig_tab(5'd16) : 16'(17'(sig_tab({1'b0, ti_q})) + 17'(step));
		sg_new = neg_q ? 16'(17'h10000 - 17'(smag)) : smag;
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DQ: begin
				mul_a = {{24{dq_diff[8]}}, dq_diff};
				mul_b = {1'b0, st_sel};
			end
			ST_SGM: begin
				mul_a = {20'b0, diff};
				mul_b = {6'b0, mag[10:0]};
			end
			ST_CONF: begin
				mul_a = {17'b0, sg_q[VI_CLS]};
				mul_b = {1'b0, sg_q[VI_OBJ]};
			end
			ST_SQW: begin
				mul_a = {17'b0, sg_q[VI_BOX2]};
				mul_b = {1'b0, sg_q[VI_BOX2]};
			end
			ST_GW: begin
				mul_a = {1'b0, sq_q};
				mul_b = {7'b0, gain_w(snap.sc, snap.an), 1'b0};
			end
			ST_SQH: begin
				mul_a = {17'b0, sg_q[VI_BOX3]};
				mul_b = {1'b0, sg_q[VI_BOX3]};
			end
			ST_GH: begin
				mul_a = {1'b0, sq_q};
				mul_b = {7'b0, gain_h(snap.sc, snap.an), 1'b0};
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Box centers in grid cells (Q.16 before the stride shift).
	always_comb begin
		px    = 26'({snap.cx, 16'b0}) + 26'({sg_q[VI_BOX0], 1'b0}) - 26'd32768;
		py    = 26'({snap.cy, 16'b0}) + 26'({sg_q[VI_BOX1], 1'b0}) - 26'd32768;
		shamt = 5'd19 + 5'(snap.sc);
	end

	// One edge per cycle: center minus or plus half size, rounded, saturated.
	always_comb begin
		h_e = {6'b0, (e_q[0] ? hw_q : hh_q)};
		t_e = e_q[1] ? ((e_q[0] ? cen_x_q : cen_y_q) + h_e)
			: ((e_q[0] ? cen_x_q : cen_y_q) - h_e);
		if ((t_e[47:45] == 3'b000) || (t_e[47:45] == 3'b111)) begin
			edge_new = t_e[45:28];
		end else begin
			edge_new = t_e[47] ? EDGE_MIN : EDGE_MAX;
		end
	end

	assign pass     = (lg_q[VI_OBJ] >= cfg.thr) && (lg_q[VI_CLS] >= cfg.thr);
	assign out_free = !out_valid_q || !out_stall;

	// Sequencer and the output register's valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			e_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_PUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					k_q <= VI_OBJ;
					if (start) begin
						state_q <= ST_DQ;
					end
				end
				ST_DQ: begin
					if (k_q == VI_BOX3) begin
						k_q     <= VI_OBJ;
						state_q <= ST_THR;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_THR: state_q <= pass ? ST_SGM : ST_IDLE;
				ST_SGM: state_q <= ST_SGF;
				ST_SGF: begin
					if (k_q == VI_BOX3) begin
						state_q <= ST_CONF;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= ST_SGM;
					end
				end
				ST_CONF: state_q <= ST_SQW;
				ST_SQW: state_q <= ST_GW;
				ST_GW: state_q <= ST_SQH;
				ST_SQH: state_q <= ST_GH;
				ST_GH: state_q <= ST_CEN;
				ST_CEN: begin
					e_q     <= '0;
					state_q <= ST_EDGE;
				end
				ST_EDGE: begin
					e_q <= e_q + 2'd1;
					if (e_q == 2'd3) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, loaded by the state that owns them.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_DQ: lg_q[k_q] <= mul_p[LOGIT_W-1:0];
			ST_SGM: begin
				pr_q  <= mul_p[23:0];
				ti_q  <= mag[14:11];
				neg_q <= lg_k[LOGIT_W-1];
				sat_q <= |mag[LOGIT_W-1:15];
			end
			ST_SGF: sg_q[k_q] <= sg_new;
			ST_CONF: conf_q <= 16'((mul_p[32:0] + 33'd32768) >> 16);
			ST_SQW: sq_q <= mul_p[31:0];
			ST_GW: hw_q <= mul_p[41:0];
			ST_SQH: sq_q <= mul_p[31:0];
			ST_GH: hh_q <= mul_p[41:0];
			ST_CEN: begin
				cen_x_q <= ({{22{px[25]}}, px} << shamt) + ROUND_HALF;
				cen_y_q <= ({{22{py[25]}}, py} << shamt) + ROUND_HALF;
			end
			ST_EDGE: edge_q[e_q] <= edge_new;
			ST_PUT: begin
				if (out_free) begin
					out_cls_q     <= snap.cls_i;
					out_conf_q    <= conf_q;
					out_edge_q[0] <= edge_q[0];
					out_edge_q[1] <= edge_q[1];
					out_edge_q[2] <= edge_q[2];
					out_edge_q[3] <= edge_q[3];
				end
			end
			default: ;
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign class_index = out_cls_q;
	assign confidence  = out_conf_q;
	assign box_top     = out_edge_q[0];
	assign box_left    = out_edge_q[1];
	assign box_bottom  = out_edge_q[2];
	assign box_right   = out_edge_q[3];

endmodule

// ===== rtl/yolo_split_head_decode_top.sv =====
// Top level of the YOLO split head decoder: config registers, byte collector
// and the shared-multiplier cell core. Depends on ysh_pkg, ysh_cfg,
// ysh_collect and ysh_core.
//
//  Channel  Handshake            Payload
//  in       in_valid / in_stall  scale_index anchor_index cell_x cell_y
//                                layer_value last_of_cell
//  out      out_valid/out_stall  class_index confidence box_top box_left
//                                box_bottom box_right
//  cfg      cfg_valid/cfg_ready  cfg_index cfg_data
//
// After the last byte of a cell with a class byte, in_stall stays high while
// the shared multiplier runs: up to the threshold test when the cell falls
// below threshold, on through the box edges when it yields a detection, plus
// any wait of the output register on out_stall. Short cells cost nothing extra.
// The result sits in an output register, so bytes of the next cell are taken
// while it waits. Reset clears the byte position, best class, sequencer and
// output valid, and resets the config registers; cfg_ready is always high.
module yolo_split_head_decode_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 scale_index,
	input  logic [1:0]                 anchor_index,
	input  logic [ysh_pkg::CELL_W-1:0] cell_x,
	input  logic [ysh_pkg::CELL_W-1:0] cell_y,
	input  logic [ysh_pkg::BYTE_W-1:0] layer_value,
	input  logic                       last_of_cell,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ysh_pkg::BYTE_W-1:0] class_index,
	output logic [15:0]                confidence,
	output logic [ysh_pkg::EDGE_W-1:0] box_top,
	output logic [ysh_pkg::EDGE_W-1:0] box_left,
	output logic [ysh_pkg::EDGE_W-1:0] box_bottom,
	output logic [ysh_pkg::EDGE_W-1:0] box_right,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ysh_pkg::CFG_IW-1:0] cfg_index,
	input  logic [ysh_pkg::CFG_DW-1:0] cfg_data
);
	import ysh_pkg::*;

	cfg_t  cfg;
	cell_t snap;
	logic  start;
	logic  busy;
	logic  in_accept;

	// Bytes are held off while a captured cell waits for or runs in the core.
	assign in_stall  = start || busy;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	ysh_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ysh_collect u_collect (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_accept),
		.scale_index  (scale_index),
		.anchor_index (anchor_index),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.layer_value  (layer_value),
		.last_of_cell (last_of_cell),
		.start        (start),
		.snap         (snap)
	);

	ysh_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.snap        (snap),
		.cfg         (cfg),
		.busy        (busy),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.class_index (class_index),
		.confidence  (confidence),
		.box_top     (box_top),
		.box_left    (box_left),
		.box_bottom  (box_bottom),
		.box_right   (box_right)
	);

endmodule

// ===== tb/ysh_checker.sv =====
// Scoreboard for the YOLO split head decoder: watches the byte, detection and
// register channels, predicts each detection and compares it field by field.
// Depends on ysh_pkg for widths, register indexes and NUM_CLASSES.
`timescale 1ns / 1ps

module ysh_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [1:0]                 scale_index,
	input  logic [1:0]                 anchor_index,
	input  logic [ysh_pkg::CELL_W-1:0] cell_x,
	input  logic [ysh_pkg::CELL_W-1:0] cell_y,
	input  logic [ysh_pkg::BYTE_W-1:0] layer_value,
	input  logic                       last_of_cell,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [ysh_pkg::BYTE_W-1:0] class_index,
	input  logic [15:0]                confidence,
	input  logic [ysh_pkg::EDGE_W-1:0] box_top,
	input  logic [ysh_pkg::EDGE_W-1:0] box_left,
	input  logic [ysh_pkg::EDGE_W-1:0] box_bottom,
	input  logic [ysh_pkg::EDGE_W-1:0] box_right,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [ysh_pkg::CFG_IW-1:0] cfg_index,
	input  logic [ysh_pkg::CFG_DW-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending
);
	import ysh_pkg::*;

	// Sigmoid samples in Q0.16 at |v| = k/2, and the stride and anchor gain tables.
	localparam longint SIG_PTS [17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428,
		63615, 64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};
	localparam longint STRIDE_PX [3] = '{8, 16, 32};
	localparam longint GAIN_W [9] = '{10, 16, 33, 30, 62, 59, 116, 156, 373};
	localparam longint GAIN_H [9] = '{13, 30, 23, 61, 45, 119, 90, 198, 326};
	localparam longint EDGE_LO = -131072;
	localparam longint EDGE_HI = 131071;

	typedef struct packed {
		logic [BYTE_W-1:0] cls;
		logic [15:0]       conf;
		logic [EDGE_W-1:0] top;
		logic [EDGE_W-1:0] left;
		logic [EDGE_W-1:0] bottom;
		logic [EDGE_W-1:0] right;
	} detection_t;

	detection_t detect_q[$];

	// Shadow of the cell collector and of the register file.
	int                  cell_pos;
	logic [BYTE_W-1:0]   box_b [4];
	logic [BYTE_W-1:0]   obj_b;
	logic [BYTE_W-1:0]   best_v;
	logic [BYTE_W-1:0]   best_i;
	logic signed [24:0]  thr_r;
	logic [7:0]          zp_r [3];
	logic [15:0]         st_r [3];
	int                  errs;

	function automatic longint dequant(input logic [7:0] b, input logic [7:0] z,
		input logic [15:0] s);
		return (longint'(b) - longint'(z)) * longint'(s);
	endfunction

	// Piecewise linear sigmoid of a Q12.12 logit, odd around one half.
	function automatic longint squash(input longint v);
		longint a;
		longint i;
		longint f;
		longint s;
		a = (v < 0) ? -v : v;
		if (a >= 32768) begin
			s = SIG_PTS[16];
		end else begin
			i = a >> 11;
			f = a & 2047;
			s = SIG_PTS[i] + (((SIG_PTS[i+1] - SIG_PTS[i]) * f + 1024) >> 11);
		end
		return (v < 0) ? 65536 - s : s;
	endfunction

	// Q.32 pixels to Q13.4, rounded half up and saturated.
	function automatic logic [EDGE_W-1:0] to_edge(input longint v);
		longint r;
		r = (v + 64'sd134217728) >>> 28;
		if (r < EDGE_LO)
			r = EDGE_LO;
		if (r > EDGE_HI)
			r = EDGE_HI;
		return r[EDGE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		detection_t got;
		detection_t want;
		int         cur;
		int         sc;
		int         an;
		int         ci;
		longint     cx;
		longint     cy;
		longint     lo;
		longint     lc;
		longint     so;
		longint     scl;
		longint     sb [4];
		longint     cen_x;
		longint     cen_y;
		longint     hw;
		longint     hh;
		if (!arst_n) begin
			cell_pos = 0;
			best_v = '0;
			best_i = '0;
			thr_r = '0;
			for (int k = 0; k < 3; k++) begin
				zp_r[k] = '0;
				st_r[k] = STEP_RESET;
			end
			detect_q.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// Detection leaving the block: compare with the oldest prediction.
			if (out_valid && !out_stall) begin
				got = '{class_index, confidence, box_top, box_left, box_bottom, box_right};
				if (detect_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: detection with none predicted: class %0d conf %0d",
							$time, got.cls, got.conf);
				end else begin
					want = detect_q.pop_front();
					if (got.cls != want.cls || got.conf != want.conf || got.top != want.top ||
						got.left != want.left || got.bottom != want.bottom ||
						got.right != want.right) begin
						errs++;
						if (errs <= 10) begin
							$display("%0t: expected class %0d conf %0d box t%0d l%0d b%0d r%0d",
								$time, want.cls, want.conf, $signed(want.top),
								$signed(want.left), $signed(want.bottom), $signed(want.right));
							$display("%0t:      got class %0d conf %0d box t%0d l%0d b%0d r%0d",
								$time, got.cls, got.conf, $signed(got.top),
								$signed(got.left), $signed(got.bottom), $signed(got.right));
						end
					end
				end
			end

			// Register writes.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_THRESHOLD: thr_r = cfg_data[24:0];
					CFG_ZP_A:      zp_r[0] = cfg_data[7:0];
					CFG_ZP_B:      zp_r[1] = cfg_data[7:0];
					CFG_ZP_C:      zp_r[2] = cfg_data[7:0];
					CFG_STEP_A:    st_r[0] = cfg_data[15:0];
					CFG_STEP_B:    st_r[1] = cfg_data[15:0];
					CFG_STEP_C:    st_r[2] = cfg_data[15:0];
					default: ;
				endcase
			end

			// Head byte: collect, and decode the cell on its last byte.
			if (in_valid && !in_stall) begin
				cur = cell_pos;
				if (cur < 4) begin
					box_b[cur] = layer_value;
				end else if (cur == 4) begin
					obj_b = layer_value;
				end else begin
					ci = cur - 5;
					if (ci < NUM_CLASSES && (ci == 0 || layer_value > best_v)) begin
						best_v = layer_value;
						best_i = ci[7:0];
					end
				end
				if (!last_of_cell) begin
					if (cell_pos < 255)
						cell_pos++;
				end else begin
					cell_pos = 0;
					if (cur >= 5) begin
						sc = (scale_index > INDEX_MAX) ? 2 : int'(scale_index);
						an = (anchor_index > INDEX_MAX) ? 2 : int'(anchor_index);
						cx = longint'(cell_x) & ((longint'(1) << GRID_BITS) - 1);
						cy = longint'(cell_y) & ((longint'(1) << GRID_BITS) - 1);
						lo = dequant(obj_b, zp_r[sc], st_r[sc]);
						lc = dequant(best_v, zp_r[sc], st_r[sc]);
						if (lo >= longint'(thr_r) && lc >= longint'(thr_r)) begin
							so = squash(lo);
							scl = squash(lc);
							for (int k = 0; k < 4; k++)
								sb[k] = squash(dequant(box_b[k], zp_r[sc], st_r[sc]));
							cen_x = (2 * sb[0] - 32768 + cx * 65536) * STRIDE_PX[sc] * 65536;
							cen_y = (2 * sb[1] - 32768 + cy * 65536) * STRIDE_PX[sc] * 65536;
							hw = 2 * sb[2] * sb[2] * GAIN_W[sc*3 + an];
							hh = 2 * sb[3] * sb[3] * GAIN_H[sc*3 + an];
							want.cls = best_i;
							want.conf = 16'((scl * so + 32768) >> 16);
							want.top = to_edge(cen_y - hh);
							want.left = to_edge(cen_x - hw);
							want.bottom = to_edge(cen_y + hh);
							want.right = to_edge(cen_x + hw);
							detect_q.push_back(want);
						end
					end
					best_v = '0;
					best_i = '0;
				end
			end

			fail_count <= errs;
			pending <= detect_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top for yolo_split_head_decode_top: clock, reset, head byte and
// register stimulus, random output stalls, watchdog and verdict.
// Depends on ysh_pkg, the decoder RTL and ysh_checker.
`timescale 1ns / 1ps

module tb;
	import ysh_pkg::*;

	localparam int WATCHDOG    = 5000;
	localparam int DRAIN       = 40;
	localparam int HOLD_CYCLES = 400;
	localparam logic [24:0] THR_MIN = 25'h1000000;
	localparam logic [24:0] THR_MAX = 25'h0FFFFFF;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        scale_index;
	logic [1:0]        anchor_index;
	logic [CELL_W-1:0] cell_x;
	logic [CELL_W-1:0] cell_y;
	logic [BYTE_W-1:0] layer_value;
	logic              last_of_cell;
	logic              out_valid;
	logic              out_stall;
	logic [BYTE_W-1:0] class_index;
	logic [15:0]       confidence;
	logic [EDGE_W-1:0] box_top;
	logic [EDGE_W-1:0] box_left;
	logic [EDGE_W-1:0] box_bottom;
	logic [EDGE_W-1:0] box_right;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	int                fail_count;
	int                pending;

	int         items_sent;
	bit         gaps_on;
	bit         squeeze;
	logic [7:0] shadow_zp [3];

	yolo_split_head_decode_top u_dut (.*);
	ysh_checker u_check (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Sender gap: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Head byte: uniform, near the zero point, or an extreme.
	function automatic logic [7:0] pick_byte(input int centre);
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 8'($urandom_range(0, 255));
		if (r < 85) begin
			v = centre + $urandom_range(0, 24) - 12;
			v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
			return 8'(v);
		end
		return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
	endfunction

	function automatic logic [15:0] pick_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 16'($urandom_range(256, 8192));
		if (r < 90)
			return 16'($urandom_range(0, 65535));
		return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
	endfunction

	// One byte transaction; called at a rising edge, returns at its acceptance edge.
	task automatic put_byte(input logic [1:0] sc, input logic [1:0] an,
		input logic [6:0] cx, input logic [6:0] cy, input logic [7:0] val, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		scale_index <= sc;
		anchor_index <= an;
		cell_x <= cx;
		cell_y <= cy;
		layer_value <= val;
		last_of_cell <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// A cell of nbytes bytes; tags on early bytes are sometimes scrambled,
	// since only the tags of the last byte count.
	task automatic put_cell(input int nbytes);
		logic [1:0] sc;
		logic [1:0] an;
		logic [6:0] cx;
		logic [6:0] cy;
		int         centre;
		bit         stray;
		sc = 2'($urandom_range(0, 3));
		an = 2'($urandom_range(0, 3));
		cx = 7'($urandom_range(0, 127));
		cy = 7'($urandom_range(0, 127));
		centre = int'(shadow_zp[(sc > INDEX_MAX) ? 2 : sc]) + $urandom_range(0, 16);
		stray = ($urandom_range(0, 9) < 3);
		for (int k = 0; k < nbytes; k++) begin
			if (k == nbytes - 1 || !stray)
				put_byte(sc, an, cx, cy, pick_byte(centre), k == nbytes - 1);
			else
				put_byte(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
					7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
					pick_byte(centre), 1'b0);
		end
	endtask

	// Random bytes with random cell ends.
	task automatic put_noise(input int n);
		for (int k = 0; k < n; k++)
			put_byte(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
				7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
				8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
	endtask

	// Stop sending and wait until every detection is out and the core is idle.
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [24:0] thr, input logic [7:0] za,
		input logic [7:0] zb, input logic [7:0] zc, input logic [15:0] sa,
		input logic [15:0] sb, input logic [15:0] scc);
		settle();
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_ZP_A, CFG_DW'(za));
		write_reg(CFG_ZP_B, CFG_DW'(zb));
		write_reg(CFG_ZP_C, CFG_DW'(zc));
		write_reg(CFG_STEP_A, CFG_DW'(sa));
		write_reg(CFG_STEP_B, CFG_DW'(sb));
		write_reg(CFG_STEP_C, CFG_DW'(scc));
		shadow_zp[0] = za;
		shadow_zp[1] = zb;
		shadow_zp[2] = zc;
	endtask

	// Receiver: random stalls, open stretches, and one long hold-off.
	initial begin : receiver
		int  r;
		int  n;
		bit  held;
		held = 0;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (squeeze && !held) begin
				held = 1;
				out_stall <= 1'b1;
				n = HOLD_CYCLES;
			end else if (r < 40) begin
				out_stall <= 1'b0;
				n = $urandom_range(1, 8);
			end else if (r < 70) begin
				out_stall <= 1'b1;
				n = $urandom_range(1, 3);
			end else if (r < 85) begin
				out_stall <= 1'b0;
				n = $urandom_range(50, 150);
			end else if (r < 97) begin
				out_stall <= 1'b1;
				n = $urandom_range(4, 15);
			end else begin
				out_stall <= 1'b1;
				n = $urandom_range(30, 80);
			end
			repeat (n) @(posedge clk);
		end
	end

	// Watchdog: ends the run after too many cycles without any transaction.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WATCHDOG) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Stimulus and verdict.
	initial begin : stimulus
		int phase;
		int phase_end;
		int r;
		int q;
		int ncls;
		int thr_i;
		items_sent = 0;
		gaps_on = 1;
		squeeze = 0;
		shadow_zp[0] = '0;
		shadow_zp[1] = '0;
		shadow_zp[2] = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		scale_index <= '0;
		anchor_index <= '0;
		cell_x <= '0;
		cell_y <= '0;
		layer_value <= '0;
		last_of_cell <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cells at reset settings. All-zero cell: logits sit exactly
		// at the threshold, so it still yields a detection.
		for (int k = 0; k < 6; k++)
			put_byte(2'd0, 2'd0, 7'd0, 7'd0, 8'd0, k == 5);
		// Cell that ends on its first byte: no detection.
		put_byte(2'd1, 2'd1, 7'd5, 7'd9, 8'hAA, 1'b1);
		// Scale and anchor code 3, far corner, saturated logits, tie for best class.
		for (int k = 0; k < 5; k++)
			put_byte(2'd3, 2'd3, 7'd127, 7'd127, 8'd255, 1'b0);
		put_byte(2'd3, 2'd3, 7'd127, 7'd127, 8'd7, 1'b0);
		put_byte(2'd3, 2'd3, 7'd127, 7'd127, 8'd200, 1'b0);
		put_byte(2'd3, 2'd3, 7'd127, 7'd127, 8'd200, 1'b1);
		// Mixed box bytes on the middle scale, equal class bytes.
		put_byte(2'd1, 2'd2, 7'd64, 7'd3, 8'd0, 1'b0);
		put_byte(2'd1, 2'd2, 7'd64, 7'd3, 8'd128, 1'b0);
		put_byte(2'd1, 2'd2, 7'd64, 7'd3, 8'd255, 1'b0);
		put_byte(2'd1, 2'd2, 7'd64, 7'd3, 8'd1, 1'b0);
		put_byte(2'd1, 2'd2, 7'd64, 7'd3, 8'd128, 1'b0);
		put_byte(2'd1, 2'd2, 7'd64, 7'd3, 8'd255, 1'b0);
		put_byte(2'd1, 2'd2, 7'd64, 7'd3, 8'd255, 1'b1);

		// Random phases, each under its own register setting.
		phase = 0;
		while (items_sent < 1500 && phase < 60) begin
			case (phase)
				0: program_regs(THR_MIN, 8'd0, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				1: program_regs(THR_MAX, 8'd255, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0);
				2: program_regs(25'd0, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: begin
					// Everything passes and cells are short, so the output
					// backs up into the input while the receiver holds off.
					program_regs(THR_MIN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), pick_step(), pick_step(), pick_step());
					squeeze = 1;
				end
				default: begin
					r = $urandom_range(0, 99);
					if (r < 30)
						thr_i = $urandom_range(0, 65536) - 32768;
					else if (r < 50)
						thr_i = 0;
					else if (r < 80)
						thr_i = -$urandom_range(0, 16777216);
					else
						thr_i = $urandom_range(0, 33554431);
					program_regs(thr_i[24:0], 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						pick_step(), pick_step(), pick_step());
				end
			endcase
			gaps_on = (phase == 3) ? 1 : ($urandom_range(0, 4) != 0);
			phase_end = items_sent + 150;
			while (items_sent < phase_end) begin
				r = $urandom_range(0, 99);
				if (phase == 3 || r < 70) begin
					q = $urandom_range(0, 99);
					if (phase == 3 || q < 70)
						ncls = $urandom_range(1, 6);
					else if (q < 90)
						ncls = $urandom_range(7, NUM_CLASSES);
					else if (q < 98)
						ncls = $urandom_range(NUM_CLASSES + 1, NUM_CLASSES + 20);
					else
						ncls = $urandom_range(251, 290);
					put_cell(5 + ncls);
				end else if (r < 85) begin
					put_cell($urandom_range(1, 5));
				end else begin
					put_noise($urandom_range(1, 8));
				end
			end
			phase++;
		end

		settle();
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
